FILE: rtl/bcdc_pkg.sv
// ----------------------------------------------------------------------------
// bcdc_pkg
// Types, constants and digit helpers for the BCD clock with button set.
// ----------------------------------------------------------------------------
package bcdc_pkg;

  localparam int unsigned NumDigits = 6;
  localparam logic [2:0]  LastDigit = 3'(NumDigits - 1);

  localparam logic [16:0] PressMax      = 17'h1FFFF;
  localparam logic [23:0] TimeWrap      = 24'h235959;
  localparam logic [7:0]  SegBlank      = 8'hFF;

  localparam logic [16:0] ShortMinReset = 17'd3000;
  localparam logic [16:0] LongMinReset  = 17'd25000;
  localparam logic [16:0] TimeoutReset  = 17'd70000;
  localparam logic [7:0]  BlinkReset    = 8'd50;

  typedef enum logic [1:0] {
    CfgShortMin  = 2'd0,
    CfgLongMin   = 2'd1,
    CfgTimeout   = 2'd2,
    CfgBlinkHalf = 2'd3
  } bcdc_cfg_idx_e;

  typedef struct packed {
    logic [16:0] short_min;
    logic [16:0] long_min;
    logic [16:0] timeout;
    logic [7:0]  blink_half;
  } bcdc_cfg_t;

  typedef struct packed {
    logic [23:0] time_bcd;
    logic        set_mode;
    logic [2:0]  set_pos;
    logic        await_rel;
    logic [16:0] press_len;
    logic [2:0]  scan_pos;
    logic [7:0]  blink_cnt;
    logic        blink_shown;
    logic        last_btn;
  } bcdc_state_t;

  typedef struct packed {
    logic [7:0]  segments;
    logic [5:0]  digit_enable;
    logic [21:0] time_value;
    logic        setting_active;
    logic [2:0]  selected_digit;
  } bcdc_result_t;

  function automatic logic [3:0] get_nib(logic [23:0] t, logic [2:0] k);
    logic [3:0] r;
    case (k)
      3'd0:    r = t[3:0];
      3'd1:    r = t[7:4];
      3'd2:    r = t[11:8];
      3'd3:    r = t[15:12];
      3'd4:    r = t[19:16];
      3'd5:    r = t[23:20];
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] digit_max(logic [23:0] t, logic [2:0] k);
    logic [3:0] r;
    case (k) inside
      3'd1, 3'd3: r = 4'd5;
      3'd4:       r = (t[23:20] == 4'd2) ? 4'd3 : 4'd9;
      3'd5:       r = (t[19:16] > 4'd3) ? 4'd1 : 4'd2;
      default:    r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] tick_second(logic [23:0] t);
    logic [23:0] r;
    logic        carry;
    logic [3:0]  d;
    logic [3:0]  mx;
    r     = t;
    carry = 1'b1;
    if (t == TimeWrap) begin
      r = '0;
    end else begin
      for (int k = 0; k < NumDigits; k++) begin
        d  = r[4*k +: 4];
        mx = digit_max(r, 3'(k));
        if (carry) begin
          if (d < mx) begin
            r[4*k +: 4] = d + 4'd1;
            carry       = 1'b0;
          end else begin
            r[4*k +: 4] = 4'd0;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [23:0] bump_digit(logic [23:0] t, logic [2:0] p);
    logic [23:0] r;
    logic [3:0]  v;
    v = get_nib(t, p);
    v = (v >= digit_max(t, p)) ? 4'd0 : v + 4'd1;
    r = t;
    for (int k = 0; k < NumDigits; k++) begin
      if (p == 3'(k)) r[4*k +: 4] = v;
    end
    return r;
  endfunction

  function automatic logic [7:0] seg_code(logic [3:0] d);
    logic [7:0] r;
    case (d)
      4'd0:    r = 8'hC0;
      4'd1:    r = 8'hF9;
      4'd2:    r = 8'hA4;
      4'd3:    r = 8'hB0;
      4'd4:    r = 8'h99;
      4'd5:    r = 8'h92;
      4'd6:    r = 8'h82;
      4'd7:    r = 8'hF8;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h90;
      default: r = SegBlank;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/bcdc_step.sv
// ----------------------------------------------------------------------------
// bcdc_step
// Next-state and display logic for one sample: button, second tick, scan.
// ----------------------------------------------------------------------------
module bcdc_step (
  input  bcdc_pkg::bcdc_cfg_t    cfg_i,
  input  bcdc_pkg::bcdc_state_t  state_i,
  input  logic                   second_tick_i,
  input  logic                   scan_tick_i,
  input  logic                   button_level_i,
  output bcdc_pkg::bcdc_state_t  state_o,
  output bcdc_pkg::bcdc_result_t result_o
);
  import bcdc_pkg::*;

  bcdc_state_t s;
  logic        adv;
  logic        inc;
  logic [7:0]  half;
  logic [8:0]  cnt_nx;
  logic        blank;

  assign half = (cfg_i.blink_half == 8'd0) ? 8'd1 : cfg_i.blink_half;

  always_comb begin
    s      = state_i;
    adv    = 1'b0;
    inc    = 1'b0;
    cnt_nx = {1'b0, state_i.blink_cnt} + 9'd1;

    if (!s.set_mode) begin
      if (button_level_i && !s.last_btn) begin
        s.set_mode    = 1'b1;
        s.time_bcd    = '0;
        s.set_pos     = '0;
        s.await_rel   = 1'b1;
        s.press_len   = '0;
        s.blink_cnt   = '0;
        s.blink_shown = 1'b0;
      end
    end else if (s.await_rel) begin
      if (!button_level_i) s.await_rel = 1'b0;
      s.press_len = '0;
    end else if (button_level_i) begin
      if (s.press_len != PressMax) s.press_len = s.press_len + 17'd1;
      if (s.press_len >= cfg_i.timeout) begin
        s.press_len = '0;
        s.await_rel = 1'b1;
        adv         = 1'b1;
      end
    end else if (s.press_len != '0) begin
      if (s.press_len >= cfg_i.long_min) begin
        adv = 1'b1;
      end else if (s.press_len > cfg_i.short_min) begin
        inc = 1'b1;
      end
      s.press_len = '0;
    end

    if (adv) begin
      if (s.set_pos == LastDigit) begin
        s.set_mode = 1'b0;
        s.set_pos  = '0;
      end else begin
        s.set_pos = s.set_pos + 3'd1;
      end
    end
    if (inc) s.time_bcd = bump_digit(s.time_bcd, s.set_pos);

    s.last_btn = button_level_i;

    if (second_tick_i && !s.set_mode) s.time_bcd = tick_second(s.time_bcd);

    if (scan_tick_i) begin
      if (s.scan_pos == LastDigit) begin
        s.scan_pos = '0;
        cnt_nx     = {1'b0, s.blink_cnt} + 9'd1;
        if (s.set_mode) begin
          if (cnt_nx >= {1'b0, half}) begin
            s.blink_cnt   = '0;
            s.blink_shown = !s.blink_shown;
          end else begin
            s.blink_cnt = cnt_nx[7:0];
          end
        end
      end else begin
        s.scan_pos = s.scan_pos + 3'd1;
      end
    end
  end

  assign state_o = s;
  assign blank   = s.set_mode && !s.blink_shown && (s.scan_pos == s.set_pos);

  always_comb begin
    result_o.segments       = blank ? SegBlank : seg_code(get_nib(s.time_bcd, s.scan_pos));
    result_o.digit_enable   = blank ? 6'd0 : (6'd1 << s.scan_pos);
    result_o.time_value     = s.time_bcd[21:0];
    result_o.setting_active = s.set_mode;
    result_o.selected_digit = s.set_mode ? s.set_pos : 3'd0;
  end

endmodule

FILE: rtl/bcd_clock_with_button_set_core.sv
// ----------------------------------------------------------------------------
// bcd_clock_with_button_set_core
// 24-hour BCD clock with one-button set and multiplexed seven-segment drive.
// ----------------------------------------------------------------------------
// Pipeline: input register, then the step logic into the state and result
// registers. Throughput: one sample per cycle while the output is not stalled;
// under output stall the result is held and a held input item stalls the input.
// Reset: time, mode, counters and handshake clear; registers take their
// default thresholds (3000, 25000, 70000, 50).
module bcd_clock_with_button_set_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        second_tick_i,
  input  logic        scan_tick_i,
  input  logic        button_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  segments_o,
  output logic [5:0]  digit_enable_o,
  output logic [21:0] time_value_o,
  output logic        setting_active_o,
  output logic [2:0]  selected_digit_o
);
  import bcdc_pkg::*;

  bcdc_cfg_t    cfg_q;
  bcdc_state_t  state_q, state_d;
  bcdc_result_t result_q, result_d;
  logic         in_valid_q;
  logic         sec_q, scan_q, btn_q;
  logic         out_valid_q;
  logic         advance;
  logic         fire;
  logic         accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_min  <= ShortMinReset;
      cfg_q.long_min   <= LongMinReset;
      cfg_q.timeout    <= TimeoutReset;
      cfg_q.blink_half <= BlinkReset;
    end else if (cfg_we_i) begin
      unique case (bcdc_cfg_idx_e'(cfg_index_i))
        CfgShortMin:  cfg_q.short_min  <= cfg_data_i;
        CfgLongMin:   cfg_q.long_min   <= cfg_data_i;
        CfgTimeout:   cfg_q.timeout    <= cfg_data_i;
        CfgBlinkHalf: cfg_q.blink_half <= cfg_data_i[7:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sec_q  <= second_tick_i;
      scan_q <= scan_tick_i;
      btn_q  <= button_level_i;
    end
    if (fire) result_q <= result_d;
  end

  bcdc_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .second_tick_i  (sec_q),
    .scan_tick_i    (scan_q),
    .button_level_i (btn_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  assign out_valid_o      = out_valid_q;
  assign segments_o       = result_q.segments;
  assign digit_enable_o   = result_q.digit_enable;
  assign time_value_o     = result_q.time_value;
  assign setting_active_o = result_q.setting_active;
  assign selected_digit_o = result_q.selected_digit;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled without a held item");

  a_enable_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(digit_enable_o))
    else $error("digit enable not one-hot");

  a_run_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !setting_active_o |-> selected_digit_o == 3'd0)
    else $error("selected digit nonzero in run mode");

  a_positions_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.scan_pos <= LastDigit && state_q.set_pos <= LastDigit)
    else $error("digit position out of range");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("state changed without a sample");
`endif

endmodule
